### rtl/u8d_pkg.sv
`timescale 1ns / 1ps
package u8d_pkg;

	// default length limit of one string in bytes
	localparam int unsigned MAX_STRING_BYTES_DEF = 4096;

	// register file
	localparam int unsigned ADDR_W       = 3;
	localparam logic        REG_IDX_MODE = 1'b0;

	// result kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_LEAD = 2'd1;
	localparam logic [1:0] ERR_CONT = 2'd2;
	localparam logic [1:0] ERR_LONG = 2'd3;

	// encoding modes
	localparam logic MODE_UTF8   = 1'b0;
	localparam logic MODE_SINGLE = 1'b1;

	// byte classes
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_MATCH = 8'hE0;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_MATCH = 8'hC0;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_MATCH  = 8'h80;
	localparam logic [7:0] LEAD2_DATA  = 8'h1F;
	localparam logic [7:0] LEAD3_DATA  = 8'h0F;
	localparam logic [7:0] CONT_DATA   = 8'h3F;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code_point;
		logic [11:0] start_position;
		logic [1:0]  byte_coverage;
		logic [12:0] parsed_bytes;
		logic [12:0] char_count;
		logic [1:0]  error_code;
	} result_t;

endpackage

### rtl/utf8_byte_stream_decoder_core.sv
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// bytes in  | byte_valid / byte_stall    | data_byte
// results   | result_valid / result_stall| kind, code_point, start_position,
//           |                            | byte_coverage, parsed_bytes, char_count,
//           |                            | error_code
// config    | apb psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// one byte per cycle sustained while result_stall is low; a taken byte passes the input
// register, then one level of decode logic into the result register
// reset clears the mode to utf-8, all string state and both valid flags
// result_stall holds the result register; the input stage keeps taking bytes
// while the result register is empty or being drained in the same cycle
module utf8_byte_stream_decoder_core #(
	parameter int unsigned MAX_STRING_BYTES = u8d_pkg::MAX_STRING_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// byte requests
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  logic [7:0]                 data_byte,
	// result requests
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [1:0]                 kind,
	output logic [15:0]                code_point,
	output logic [11:0]                start_position,
	output logic [1:0]                 byte_coverage,
	output logic [12:0]                parsed_bytes,
	output logic [12:0]                char_count,
	output logic [1:0]                 error_code,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [u8d_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic             mode;
	logic             res_room;
	logic             res_load;
	u8d_pkg::result_t res;
	u8d_pkg::result_t res_out;

	// encoding mode register
	u8d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	// input register, string state and decode logic
	u8d_decode #(
		.MAX_STRING_BYTES (MAX_STRING_BYTES)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.res_room   (res_room),
		.res_load   (res_load),
		.res        (res)
	);

	// result register toward the consumer
	u8d_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res          (res),
		.res_room     (res_room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.res_out      (res_out)
	);

	// result fields onto their own ports
	assign kind           = res_out.kind;
	assign code_point     = res_out.code_point;
	assign start_position = res_out.start_position;
	assign byte_coverage  = res_out.byte_coverage;
	assign parsed_bytes   = res_out.parsed_bytes;
	assign char_count     = res_out.char_count;
	assign error_code     = res_out.error_code;

endmodule

### rtl/u8d_cfg.sv
`timescale 1ns / 1ps
module u8d_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [u8d_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic                        mode
);

	logic mode_q;
	logic hit_mode;

	assign hit_mode = (paddr[u8d_pkg::ADDR_W-1:2] == u8d_pkg::REG_IDX_MODE);
	assign pready   = 1'b1;
	assign mode     = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= u8d_pkg::MODE_UTF8;
		end else if (psel && penable && pwrite && hit_mode) begin
			mode_q <= pwdata[0];
		end
	end

	// low address bits select bytes of the word and are ignored
	assign prdata = hit_mode ? {31'd0, mode_q} : 32'd0;

endmodule

### rtl/u8d_decode.sv
`timescale 1ns / 1ps
module u8d_decode #(
	parameter int unsigned MAX_STRING_BYTES = u8d_pkg::MAX_STRING_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mode,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       data_byte,
	input  logic             res_room,
	output logic             res_load,
	output u8d_pkg::result_t res
);

	localparam int unsigned POS_W = $clog2(MAX_STRING_BYTES + 1);
	localparam logic [POS_W:0] LIMIT = (POS_W + 1)'(MAX_STRING_BYTES);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// string state
	logic [1:0]       pend_q, pend_d;
	logic [1:0]       seq_q, seq_d;
	logic [15:0]      acc_q, acc_d;
	logic [POS_W-1:0] start_q, start_d;
	logic [POS_W-1:0] bpos_q, bpos_d;
	logic [POS_W-1:0] chars_q, chars_d;
	logic             skip_q, skip_d;

	logic             fire;
	logic             has_res;
	logic [POS_W:0]   pos_cont;
	logic [POS_W:0]   bpos_wide;
	logic [31:0]      bpos_ext;
	logic [31:0]      start_ext;
	logic [31:0]      chars_ext;
	logic [31:0]      chars_inc_ext;
	logic [15:0]      acc_shift;
	logic             is_cont;

	assign byte_stall = valid_s1 & ~res_room;
	assign fire       = valid_s1 & res_room;
	assign res_load   = fire & has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= data_byte;
		end
	end

	assign bpos_wide     = {1'b0, bpos_q};
	assign pos_cont      = bpos_wide + (POS_W + 1)'(seq_q - pend_q);
	assign bpos_ext      = 32'(bpos_q);
	assign start_ext     = 32'(start_q);
	assign chars_ext     = 32'(chars_q);
	assign chars_inc_ext = chars_ext + 32'd1;
	assign acc_shift     = {acc_q[9:0], byte_s1[5:0] & u8d_pkg::CONT_DATA[5:0]};
	assign is_cont       = ((byte_s1 & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_MATCH);

	always_comb begin
		pend_d  = pend_q;
		seq_d   = seq_q;
		acc_d   = acc_q;
		start_d = start_q;
		bpos_d  = bpos_q;
		chars_d = chars_q;
		skip_d  = skip_q;
		has_res = 1'b0;
		res     = '0;
		res.char_count = chars_ext[12:0];

		if (skip_q) begin
			// drop bytes up to the terminator
			if (byte_s1 == 8'd0) begin
				pend_d  = '0;
				seq_d   = '0;
				acc_d   = '0;
				start_d = '0;
				bpos_d  = '0;
				chars_d = '0;
				skip_d  = 1'b0;
			end
		end else if (byte_s1 == 8'd0) begin
			has_res          = 1'b1;
			res.parsed_bytes = bpos_ext[12:0];
			if (mode == u8d_pkg::MODE_UTF8 && pend_q != 2'd0) begin
				// terminator inside a sequence
				res.kind           = u8d_pkg::KIND_ERROR;
				res.start_position = start_ext[11:0];
				res.error_code     = u8d_pkg::ERR_CONT;
			end else begin
				res.kind = u8d_pkg::KIND_DONE;
			end
			pend_d  = '0;
			seq_d   = '0;
			acc_d   = '0;
			start_d = '0;
			bpos_d  = '0;
			chars_d = '0;
		end else if (mode == u8d_pkg::MODE_SINGLE || pend_q == 2'd0) begin
			// first byte of a character
			has_res = 1'b1;
			pend_d  = '0;
			seq_d   = '0;
			acc_d   = '0;
			if (bpos_wide >= LIMIT) begin
				res.kind           = u8d_pkg::KIND_ERROR;
				res.start_position = bpos_ext[11:0];
				res.parsed_bytes   = bpos_ext[12:0];
				res.error_code     = u8d_pkg::ERR_LONG;
				skip_d             = 1'b1;
			end else if (mode == u8d_pkg::MODE_SINGLE || !byte_s1[7]) begin
				res.kind           = u8d_pkg::KIND_CHAR;
				res.code_point     = {8'd0, byte_s1};
				res.start_position = bpos_ext[11:0];
				res.byte_coverage  = 2'd1;
				res.char_count     = chars_inc_ext[12:0];
				bpos_d             = bpos_q + POS_W'(1);
				chars_d            = chars_q + POS_W'(1);
			end else if ((byte_s1 & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_MATCH) begin
				has_res = 1'b0;
				acc_d   = {8'd0, byte_s1 & u8d_pkg::LEAD2_DATA};
				pend_d  = 2'd1;
				seq_d   = 2'd2;
				start_d = bpos_q;
			end else if ((byte_s1 & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_MATCH) begin
				has_res = 1'b0;
				acc_d   = {8'd0, byte_s1 & u8d_pkg::LEAD3_DATA};
				pend_d  = 2'd2;
				seq_d   = 2'd3;
				start_d = bpos_q;
			end else begin
				res.kind           = u8d_pkg::KIND_ERROR;
				res.start_position = bpos_ext[11:0];
				res.parsed_bytes   = bpos_ext[12:0];
				res.error_code     = u8d_pkg::ERR_LEAD;
				skip_d             = 1'b1;
			end
		end else begin
			// continuation byte
			if (pos_cont >= LIMIT || !is_cont) begin
				has_res            = 1'b1;
				res.kind           = u8d_pkg::KIND_ERROR;
				res.start_position = start_ext[11:0];
				res.parsed_bytes   = bpos_ext[12:0];
				res.error_code     = (pos_cont >= LIMIT) ? u8d_pkg::ERR_LONG
				                                         : u8d_pkg::ERR_CONT;
				pend_d             = '0;
				seq_d              = '0;
				acc_d              = '0;
				skip_d             = 1'b1;
			end else begin
				acc_d  = acc_shift;
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					has_res            = 1'b1;
					res.kind           = u8d_pkg::KIND_CHAR;
					res.code_point     = acc_shift;
					res.start_position = start_ext[11:0];
					res.byte_coverage  = seq_q;
					res.char_count     = chars_inc_ext[12:0];
					seq_d              = '0;
					bpos_d             = bpos_q + POS_W'(seq_q);
					chars_d            = chars_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			seq_q   <= '0;
			acc_q   <= '0;
			start_q <= '0;
			bpos_q  <= '0;
			chars_q <= '0;
			skip_q  <= 1'b0;
		end else if (fire) begin
			pend_q  <= pend_d;
			seq_q   <= seq_d;
			acc_q   <= acc_d;
			start_q <= start_d;
			bpos_q  <= bpos_d;
			chars_q <= chars_d;
			skip_q  <= skip_d;
		end
	end

	a_skip_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (pend_q == 2'd0))
		else $error("skip mode with a sequence still pending");

	a_seq_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 2'd0) |-> (seq_q > pend_q))
		else $error("pending count not below sequence length");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bpos_wide <= LIMIT)
		else $error("byte position past the length limit");

	a_chars_le_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		chars_q <= bpos_q)
		else $error("more characters than consumed bytes");

	a_error_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.kind == u8d_pkg::KIND_ERROR && byte_s1 != 8'd0) |=> skip_q)
		else $error("error result did not start skipping");

endmodule

### rtl/u8d_out.sv
`timescale 1ns / 1ps
module u8d_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_load,
	input  u8d_pkg::result_t res,
	output logic             res_room,
	output logic             result_valid,
	input  logic             result_stall,
	output u8d_pkg::result_t res_out
);

	logic             valid_q;
	u8d_pkg::result_t res_q;

	assign res_room     = ~valid_q | ~result_stall;
	assign result_valid = valid_q;
	assign res_out      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule
